### sv/ntick_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntick_pkg
// Shared types and constants for the nine-patch edge tick scanner: scan
// phases, error codes, result kinds and the packed result record.
// ----------------------------------------------------------------------------
package ntick_pkg;

  // Longest edge, counted in positions including the corner.
  localparam int EDGE_MAX = 4096;

  localparam int POS_W   = 13;
  localparam int START_W = 12;
  localparam int CNT_W   = 8;
  localparam int EPOS_W  = 14;

  // Position at which an edge is forced to end.
  localparam logic [POS_W-1:0] POS_FORCE_END = POS_W'(EDGE_MAX - 2);

  // Scan phases.
  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_INSIDE  = 2'd1;
  localparam logic [1:0] PH_OUTSIDE = 2'd2;

  // Error codes; ERR_NONE marks an empty pending slot.
  localparam logic [2:0] ERR_MULTIPLE     = 3'd0;
  localparam logic [2:0] ERR_PARTIAL      = 3'd1;
  localparam logic [2:0] ERR_TRANS_TICK   = 3'd2;
  localparam logic [2:0] ERR_WHITE_SOLID  = 3'd3;
  localparam logic [2:0] ERR_WHITE_TICK   = 3'd4;
  localparam logic [2:0] ERR_NONE_FOUND   = 3'd5;
  localparam logic [2:0] ERR_NONE         = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_SPAN  = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BPP      = 2'd0;
  localparam logic [1:0] REG_TRANS    = 2'd1;
  localparam logic [1:0] REG_MULTI    = 2'd2;
  localparam logic [1:0] REG_REQUIRED = 2'd3;

  // Pixel classification.
  typedef struct packed {
    logic       tick;
    logic       err_set;
    logic [2:0] err_code;
  } cls_t;

  // One result record.
  typedef struct packed {
    logic [1:0]         kind;
    logic [START_W-1:0] region_start;
    logic [POS_W-1:0]   region_end;
    logic [CNT_W-1:0]   region_count;
    logic [2:0]         error_code;
    logic [EPOS_W-1:0]  error_position;
    logic               last;
  } res_t;

  // Results produced by one pixel, in order.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### sv/ntick_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntick_classifier
// Classifies one border pixel as tick or not, and flags a colour error,
// under transparent-frame or white-frame rules.
// ----------------------------------------------------------------------------
module ntick_classifier (
  input  logic [31:0]       pixel,
  input  logic [2:0]        bpp,
  input  logic              transparent,
  output ntick_pkg::cls_t   cls
);
  import ntick_pkg::*;

  logic [1:0]  bsel;
  logic        full4;
  logic [31:0] mask;
  logic [31:0] color;
  logic [31:0] tick_c;
  logic [31:0] lb_c;
  logic [7:0]  b3;
  logic        low_nz;

  // Clamp the byte count and build the colour mask.
  always_comb begin
    case (bpp)
      3'd0, 3'd1: bsel = 2'd0;
      3'd2:       bsel = 2'd1;
      3'd3:       bsel = 2'd2;
      default:    bsel = 2'd3;
    endcase
    case (bsel)
      2'd0:    mask = 32'h0000_00FF;
      2'd1:    mask = 32'h0000_FFFF;
      2'd2:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  assign full4  = (bsel == 2'd3);
  assign color  = pixel & mask;
  assign b3     = color[31:24];
  assign low_nz = (color[23:0] != 24'd0);
  assign tick_c = full4 ? 32'hFF00_0000 : 32'h0000_0000;
  assign lb_c   = full4 ? 32'hFF00_00FF : 32'h0000_00FF;

  // Rule evaluation.
  always_comb begin
    cls.tick     = 1'b0;
    cls.err_set  = 1'b0;
    cls.err_code = ERR_NONE;
    if (transparent) begin
      if (b3 == 8'd0) begin
        cls.tick = 1'b0;
      end else if (color == lb_c) begin
        cls.tick = 1'b0;
      end else if (color == tick_c) begin
        cls.tick = 1'b1;
      end else if (b3 != 8'hFF) begin
        cls.err_set  = 1'b1;
        cls.err_code = ERR_PARTIAL;
      end else begin
        cls.tick = 1'b1;
        if (low_nz) begin
          cls.err_set  = 1'b1;
          cls.err_code = ERR_TRANS_TICK;
        end
      end
    end else begin
      // A non-opaque alpha is flagged first; a bad tick colour overrides it.
      if (full4 && (b3 != 8'hFF)) begin
        cls.err_set  = 1'b1;
        cls.err_code = ERR_WHITE_SOLID;
      end
      if (color == mask) begin
        cls.tick = 1'b0;
      end else if (color == tick_c) begin
        cls.tick = 1'b1;
      end else if (color == lb_c) begin
        cls.tick = 1'b0;
      end else if (low_nz) begin
        cls.err_set  = 1'b1;
        cls.err_code = ERR_WHITE_TICK;
      end else begin
        cls.tick = 1'b1;
      end
    end
  end

endmodule

### sv/ntick_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntick_scanner
// Run tracker for one edge: holds the scan state, turns each classified
// pixel into zero, one or two results and resets itself at edge end.
// ----------------------------------------------------------------------------
module ntick_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ntick_pkg::cls_t   cls,
  input  logic              last_pixel,
  input  logic              multi_allowed,
  input  logic              required,
  output ntick_pkg::push_t  push
);
  import ntick_pkg::*;

  logic [1:0]         phase_r, phase_nxt;
  logic [START_W-1:0] open_r, open_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               found_r, found_nxt;
  logic [2:0]         pend_r, pend_nxt;
  logic               halt_r, halt_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               last;
  logic               err;
  logic               a_v;
  logic [POS_W-1:0]   pos_m1;
  logic [2:0]         pend_new;
  logic [1:0]         ph_a;
  logic [START_W-1:0] open_a;
  logic               found_a;
  logic [CNT_W-1:0]   cnt_a;
  res_t               res_a, res_b, res_c;

  assign last     = last_pixel || (pos_r >= POS_FORCE_END);
  assign pos_m1   = pos_r - POS_W'(1);
  assign pend_new = cls.err_set ? cls.err_code : pend_r;

  // Per-pixel scan step.
  always_comb begin
    ph_a    = phase_r;
    open_a  = open_r;
    found_a = found_r;
    cnt_a   = cnt_r;
    err     = 1'b0;
    a_v     = 1'b0;
    res_a   = '0;
    if (cls.tick) begin
      if ((phase_r == PH_START) || ((phase_r == PH_OUTSIDE) && multi_allowed)) begin
        open_a  = pos_m1[START_W-1:0];
        ph_a    = PH_INSIDE;
        found_a = 1'b1;
        cnt_a   = cnt_r + CNT_W'(1);
      end else if (phase_r == PH_OUTSIDE) begin
        a_v                  = 1'b1;
        err                  = 1'b1;
        res_a.kind           = KIND_ERROR;
        res_a.error_code     = ERR_MULTIPLE;
        res_a.error_position = EPOS_W'(pos_r);
      end
    end else if (pend_new == ERR_NONE) begin
      if (phase_r == PH_INSIDE) begin
        a_v                = 1'b1;
        res_a.kind         = KIND_SPAN;
        res_a.region_start = open_r;
        res_a.region_end   = pos_m1;
        ph_a               = PH_OUTSIDE;
      end
    end else begin
      a_v                  = 1'b1;
      err                  = 1'b1;
      res_a.kind           = KIND_ERROR;
      res_a.error_code     = pend_new;
      res_a.error_position = EPOS_W'(pos_r);
    end
    res_a.region_count = cnt_a;
  end

  // Edge-end results: closing span, then success or missing run.
  always_comb begin
    res_b              = '0;
    res_b.kind         = KIND_SPAN;
    res_b.region_start = open_a;
    res_b.region_end   = pos_r;
    res_b.region_count = cnt_a;
    res_c              = '0;
    res_c.region_count = cnt_a;
    if (required && !found_a) begin
      res_c.kind           = KIND_ERROR;
      res_c.error_code     = ERR_NONE_FOUND;
      res_c.error_position = '1;
    end else begin
      res_c.kind = KIND_OK;
    end
  end

  // Result selection and next state.
  always_comb begin
    push      = '0;
    phase_nxt = phase_r;
    open_nxt  = open_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    pend_nxt  = pend_r;
    halt_nxt  = halt_r;
    cnt_nxt   = cnt_r;
    if (step) begin
      if (halt_r) begin
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        phase_nxt = ph_a;
        open_nxt  = open_a;
        found_nxt = found_a;
        cnt_nxt   = cnt_a;
        pend_nxt  = pend_new;
        pos_nxt   = pos_r + POS_W'(1);
        if (a_v && err) begin
          push.num     = 2'd1;
          push.r0      = res_a;
          push.r0.last = 1'b1;
          halt_nxt     = 1'b1;
        end else if (last) begin
          // A span closed by the final pixel is followed by the edge verdict.
          if (a_v) begin
            push.num     = 2'd2;
            push.r0      = res_a;
            push.r1      = res_c;
            push.r1.last = 1'b1;
          end else if (ph_a == PH_INSIDE) begin
            push.num     = 2'd2;
            push.r0      = res_b;
            push.r1      = res_c;
            push.r1.last = 1'b1;
          end else begin
            push.num     = 2'd1;
            push.r0      = res_c;
            push.r0.last = 1'b1;
          end
        end else if (a_v) begin
          push.num     = 2'd1;
          push.r0      = res_a;
          push.r0.last = 1'b1;
        end
      end
      // Any edge end clears the whole scan state.
      if (last) begin
        phase_nxt = PH_START;
        open_nxt  = '0;
        pos_nxt   = POS_W'(1);
        found_nxt = 1'b0;
        pend_nxt  = ERR_NONE;
        halt_nxt  = 1'b0;
        cnt_nxt   = '0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      open_r  <= '0;
      pos_r   <= POS_W'(1);
      found_r <= 1'b0;
      pend_r  <= ERR_NONE;
      halt_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      open_r  <= open_nxt;
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
      pend_r  <= pend_nxt;
      halt_r  <= halt_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### sv/ntick_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntick_out_queue
// Four-entry result queue: takes up to two results per cycle and hands one
// per cycle to the output channel whenever pop is asserted.
// ----------------------------------------------------------------------------
module ntick_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  ntick_pkg::push_t  push,
  output logic              room,
  output logic              head_valid,
  output ntick_pkg::res_t   head,
  input  logic              pop
);
  import ntick_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign head_valid = (cnt_r != 3'd0);
  assign room       = (cnt_r <= 3'd2);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + push.num;
    rd_nxt  = rd_r + {1'b0, do_pop};
    cnt_nxt = cnt_r + {1'b0, push.num} - {2'b00, do_pop};
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/nine_patch_edge_tick_scanner.sv
`timescale 1ns / 1ps
// A result is queued when its pixel is accepted and offered from the queue head.
// Throughput: one pixel per cycle; the edge-ending pixel can yield two results,
// which drain one per cycle while out_tready is high through a four-entry
// result queue, and in_tready falls while that queue holds more than two results.
// Reset: configuration returns to its defaults, scan state and queue are cleared.
// ----------------------------------------------------------------------------
// nine_patch_edge_tick_scanner
// Top level: configuration registers, pixel classifier, run scanner and
// result queue for one nine-patch border edge at a time.
// ----------------------------------------------------------------------------
module nine_patch_edge_tick_scanner (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_value
  input  logic        in_tlast,   // last_pixel
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] region_start, [24:12] region_end, [32:25] region_count,
  // [35:33] error_code, [49:36] error_position, [55:50] zero
  output logic [55:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] result_kind
  output logic        out_tlast,  // last_result
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ntick_pkg::*;

  logic [2:0] bpp_r;
  logic       trans_r;
  logic       multi_r;
  logic       req_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       step;
  logic       room;
  cls_t       cls;
  push_t      push;
  res_t       head;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= 3'd4;
      trans_r <= 1'b0;
      multi_r <= 1'b1;
      req_r   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BPP:      bpp_r   <= cfg_pwdata[2:0];
        REG_TRANS:    trans_r <= cfg_pwdata[0];
        REG_MULTI:    multi_r <= cfg_pwdata[0];
        REG_REQUIRED: req_r   <= cfg_pwdata[0];
        default:      ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_BPP:      cfg_prdata = {29'd0, bpp_r};
      REG_TRANS:    cfg_prdata = {31'd0, trans_r};
      REG_MULTI:    cfg_prdata = {31'd0, multi_r};
      REG_REQUIRED: cfg_prdata = {31'd0, req_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Pixel request handshake.
  assign in_tready = room;
  assign step      = in_tvalid && in_tready;

  ntick_classifier u_cls (
    .pixel       (in_tdata),
    .bpp         (bpp_r),
    .transparent (trans_r),
    .cls         (cls)
  );

  ntick_scanner u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cls           (cls),
    .last_pixel    (in_tlast),
    .multi_allowed (multi_r),
    .required      (req_r),
    .push          (push)
  );

  ntick_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  // Result packing.
  assign out_tdata = {6'd0, head.error_position, head.error_code, head.region_count,
                      head.region_end, head.region_start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
